/* rtl/core/base64_stream_codec_unit_macros.svh */
// ----------------------------------------------------------------------------
// base64_stream_codec_unit_macros
// Assertion macros shared by the codec modules (clk / arst_n in scope).
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_UNIT_MACROS_SVH
`define BASE64_STREAM_CODEC_UNIT_MACROS_SVH

// same-cycle implication
`define B64C_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define B64C_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/b64c_pkg.sv */
// ----------------------------------------------------------------------------
// b64c_pkg
// Types, constants and alphabet functions of the base64 stream codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64c_pkg;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// group handed from the group unit to the emitter; chars[0] goes out first
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [2:0]      count;
		logic            last;
	} group_t;

	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)      return 8'h41 + w;
		else if (v < 6'd52) return 8'h61 + w - 8'd26;
		else if (v < 6'd62) return 8'h30 + w - 8'd52;
		else if (v == 6'd62) return 8'h2B;
		else                return 8'h2F;
	endfunction

	function automatic logic [5:0] dec_sextet(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c inside {[8'h41:8'h5A]})      d = c - 8'h41;
		else if (c inside {[8'h61:8'h7A]}) d = c - 8'h61 + 8'd26;
		else if (c inside {[8'h30:8'h39]}) d = c - 8'h30 + 8'd52;
		else if (c == 8'h2B)               d = 8'd62;
		else if (c == 8'h2F)               d = 8'd63;
		return d[5:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/b64c_in_if.sv */
// ----------------------------------------------------------------------------
// b64c_in_if
// Input word channel: valid/ready with byte and end-of-message flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64c_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink   (input valid, in_byte, in_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/b64c_out_if.sv */
// ----------------------------------------------------------------------------
// b64c_out_if
// Output word channel: valid/ready with byte and end-of-message flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64c_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, out_byte, out_last, input ready);
	modport sink   (input valid, out_byte, out_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/b64c_group.sv */
// ----------------------------------------------------------------------------
// b64c_group
// Input register, direction register and group gathering; adds each accepted
// word to the group and hands out the group once it is full or the message ends.
// ----------------------------------------------------------------------------
`default_nettype none

module b64c_group (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_wr_en,
	input  wire logic    cfg_wr_data,
	b64c_in_if.sink      in_word,
	input  wire logic    buf_free,
	output logic         grp_valid,
	output b64c_pkg::group_t grp
);

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic        dir_q;
	logic [23:0] bits_q;
	logic [1:0]  fill_q;
	logic [1:0]  pads_q;

	logic        advance;
	logic        emit;
	logic [23:0] bits_d;
	logic [1:0]  fill_d;
	logic [1:0]  pads_d;

	// words that only extend the group move on while the buffer drains
	assign advance       = vld_s1 && (buf_free || !emit);
	assign in_word.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_word.ready) begin
			vld_s1 <= in_word.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_word.valid && in_word.ready) begin
			byte_s1 <= in_word.in_byte;
			last_s1 <= in_word.in_last;
		end
	end

	always_comb begin
		logic [23:0] base;
		logic [1:0]  fe;
		logic [5:0]  sx;
		logic [2:0]  psum;
		logic [1:0]  pcap;
		bits_d    = bits_q;
		fill_d    = fill_q;
		pads_d    = pads_q;
		emit      = 1'b0;
		grp       = '0;
		base      = bits_q;
		fe        = fill_q;
		sx        = 6'd0;
		psum      = 3'd0;
		pcap      = 2'd0;
		if (dir_q == b64c_pkg::DIR_ENCODE) begin
			if (fill_q == 2'd3) begin
				base = 24'd0;
				fe   = 2'd0;
			end
			case (fe)
				2'd0:    bits_d = base | {byte_s1, 16'd0};
				2'd1:    bits_d = base | {8'd0, byte_s1, 8'd0};
				default: bits_d = base | {16'd0, byte_s1};
			endcase
			fill_d = fe + 2'd1;
			emit   = (fe == 2'd2) || last_s1;
			grp.chars[0] = b64c_pkg::enc_char(bits_d[23:18]);
			grp.chars[1] = b64c_pkg::enc_char(bits_d[17:12]);
			grp.chars[2] = (fe != 2'd0) ? b64c_pkg::enc_char(bits_d[11:6])
				: b64c_pkg::PAD_CHAR;
			grp.chars[3] = (fe == 2'd2) ? b64c_pkg::enc_char(bits_d[5:0])
				: b64c_pkg::PAD_CHAR;
			grp.count = 3'd4;
		end else begin
			if (byte_s1 == b64c_pkg::PAD_CHAR) begin
				if (pads_q != 2'd3) pads_d = pads_q + 2'd1;
			end else begin
				sx = b64c_pkg::dec_sextet(byte_s1);
				case (fill_q)
					2'd0:    bits_d = bits_q | {sx, 18'd0};
					2'd1:    bits_d = bits_q | {6'd0, sx, 12'd0};
					2'd2:    bits_d = bits_q | {12'd0, sx, 6'd0};
					default: bits_d = bits_q | {18'd0, sx};
				endcase
			end
			fill_d = fill_q + 2'd1;
			emit   = (fill_q == 2'd3) || last_s1;
			psum   = {1'b0, pads_d} + {1'b0, 2'd3 - fill_q};
			pcap   = (psum > 3'd2) ? 2'd2 : psum[1:0];
			grp.chars[0] = bits_d[23:16];
			grp.chars[1] = bits_d[15:8];
			grp.chars[2] = bits_d[7:0];
			grp.chars[3] = 8'd0;
			grp.count    = 3'd3 - {1'b0, pcap};
		end
		grp.last = last_s1;
	end

	assign grp_valid = advance && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= b64c_pkg::DIR_ENCODE;
			bits_q <= 24'd0;
			fill_q <= 2'd0;
			pads_q <= 2'd0;
		end else if (cfg_wr_en) begin
			dir_q  <= cfg_wr_data;
			bits_q <= 24'd0;
			fill_q <= 2'd0;
			pads_q <= 2'd0;
		end else if (advance) begin
			if (emit) begin
				bits_q <= 24'd0;
				fill_q <= 2'd0;
				pads_q <= 2'd0;
			end else begin
				bits_q <= bits_d;
				fill_q <= fill_d;
				pads_q <= pads_d;
			end
		end
	end

`include "base64_stream_codec_unit_macros.svh"

	`B64C_ASSERT_NOW(a_enc_fill, dir_q == b64c_pkg::DIR_ENCODE, fill_q != 2'd3, "encode fill overrun")
	`B64C_ASSERT_NOW(a_enc_nopad, dir_q == b64c_pkg::DIR_ENCODE, pads_q == 2'd0, "pad count in encode")

endmodule

`default_nettype wire

/* rtl/core/b64c_emit.sv */
// ----------------------------------------------------------------------------
// b64c_emit
// Result buffer: holds one group of up to four words and drains it one
// word per cycle onto the output channel while the channel is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module b64c_emit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        grp_valid,
	input  b64c_pkg::group_t grp,
	output logic             buf_free,
	b64c_out_if.source       out_word
);

	logic [3:0][7:0] chars_q;
	logic [2:0]      cnt_q;
	logic            last_q;
	logic            pop;

	assign pop      = out_word.valid && out_word.ready;
	assign buf_free = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_word.ready);

	assign out_word.valid    = cnt_q != 3'd0;
	assign out_word.out_byte = chars_q[0];
	assign out_word.out_last = last_q && (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (grp_valid) begin
			cnt_q <= grp.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_valid) begin
			chars_q <= grp.chars;
			last_q  <= grp.last;
		end else if (pop) begin
			chars_q <= {8'd0, chars_q[3:1]};
		end
	end

`include "base64_stream_codec_unit_macros.svh"

	`B64C_ASSERT_NOW(a_load_free, grp_valid, buf_free, "group loaded over pending words")
	`B64C_ASSERT_NOW(a_load_cnt, grp_valid, grp.count != 3'd0 && grp.count <= 3'd4, "bad group size")
	`B64C_ASSERT_NEXT(a_drain, pop && cnt_q > 3'd1, cnt_q == $past(cnt_q) - 3'd1, "drain count slip")

endmodule

`default_nettype wire

/* rtl/core/base64_stream_codec_unit.sv */
// An accepted input word is held in the input register; a completed group is
// loaded into the result buffer. Throughput: one input word per cycle while no
// group completes; a group holds 4 words encoding and 1..3 decoding, drained
// by the one-word-per-cycle output buffer while the channel is ready.
// Reset: arst_n clears the pipeline, the result buffer and the group state,
// and selects encode.
// ----------------------------------------------------------------------------
// base64_stream_codec_unit
// Streaming base64 encoder/decoder, standard alphabet, direction register.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_codec_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_wr_en,
	input  wire logic  cfg_wr_data,
	b64c_in_if.sink    in_word,
	b64c_out_if.source out_word
);

	logic             grp_valid;
	logic             buf_free;
	b64c_pkg::group_t grp;

	b64c_group u_group (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_word    (in_word),
		.buf_free   (buf_free),
		.grp_valid  (grp_valid),
		.grp        (grp)
	);

	b64c_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.grp_valid(grp_valid),
		.grp      (grp),
		.buf_free (buf_free),
		.out_word (out_word)
	);

endmodule

`default_nettype wire
